>>> hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Request and result types, opcode and status codes of the positional list
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 5;

  // opcodes
  localparam logic [2:0] OP_INS_FIRST = 3'd0;
  localparam logic [2:0] OP_INS_LAST  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_FIRST = 3'd3;
  localparam logic [2:0] OP_DEL_LAST  = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_LIST_ALL  = 3'd6;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] element;
    logic [CountW-1:0]        entry_count;
    logic                     last;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// The list is held packed in list order in one RAM of Capacity words; the
// entry count sits in a register. One request is processed at a time. An
// insert or delete anywhere but the back of the list moves every entry behind
// the slot by one word through the RAM's single read and write port, one word
// a cycle. An insert then writes the new value into the freed slot; an insert
// at the back writes it at once. A delete of the last entry, a refused or
// unused request and a listing of an empty list go straight to the result.
// List all streams one entry a cycle while the result side keeps up. The
// result register frees the request side, so a new request is taken while
// the last result still waits.
`default_nettype none

module positional_list_engine_core #(
  parameter int unsigned Capacity = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ple_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ple_pkg::out_rsp_t      out_rsp_o
);

  import ple_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOVE  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRV   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_LIST  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [AW-1:0]     pend_dst_q, pend_dst_d;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     end_q, end_d;
  logic              up_q, up_d;
  logic              ins_q, ins_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [1:0]        status_q, status_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  out_rsp_t          out_q, out_d;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [ValueW-1:0] wr_data, rd_data;

  logic              out_free;
  logic              accept;
  logic [8:0]        pos_ext, cnt_ext;
  logic [AW-1:0]     cnt_m1, pos_m1;
  logic              full, empty;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  assign pos_ext = 9'(in_req_i.position);
  assign cnt_ext = 9'(count_q);
  assign cnt_m1  = AW'(count_q - CW'(1));
  assign pos_m1  = AW'(in_req_i.position - 8'd1);
  assign full    = (cnt_ext >= 9'(Capacity));
  assign empty   = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    pend_dst_d  = pend_dst_q;
    src_d       = src_q;
    end_d       = end_q;
    up_d        = up_q;
    ins_d       = ins_q;
    idx_d       = idx_q;
    val_d       = val_q;
    status_d    = status_q;
    ptr_d       = ptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = src_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          val_d    = in_req_i.value;
          state_d  = S_RESP;
          case (in_req_i.opcode)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (in_req_i.opcode == OP_INS_AT &&
                           (pos_ext == 9'd0 || pos_ext > cnt_ext + 9'd1)) begin
                status_d = ST_BAD_POS;
              end else begin
                idx_d = (in_req_i.opcode == OP_INS_FIRST) ? '0 :
                        (in_req_i.opcode == OP_INS_LAST)  ? AW'(count_q) : pos_m1;
                count_d = count_q + CW'(1);
                ins_d   = 1'b1;
                up_d    = 1'b1;
                src_d   = cnt_m1;
                end_d   = idx_d;
                // shift the tail up unless the slot is at the back
                state_d = (AW'(count_q) != idx_d) ? S_MOVE : S_WRV;
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (in_req_i.opcode == OP_DEL_AT &&
                           (pos_ext == 9'd0 || pos_ext > cnt_ext)) begin
                status_d = ST_BAD_POS;
              end else begin
                idx_d = (in_req_i.opcode == OP_DEL_FIRST) ? '0 :
                        (in_req_i.opcode == OP_DEL_LAST)  ? cnt_m1 : pos_m1;
                count_d = count_q - CW'(1);
                ins_d   = 1'b0;
                up_d    = 1'b0;
                src_d   = idx_d + AW'(1);
                end_d   = cnt_m1;
                state_d = (idx_d != cnt_m1) ? S_MOVE : S_RESP;
              end
            end
            OP_LIST_ALL: begin
              if (!empty) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = S_LIST;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_MOVE: begin
        rd_en      = 1'b1;
        rd_addr    = src_q;
        pend_d     = 1'b1;
        pend_dst_d = up_q ? src_q + AW'(1) : src_q - AW'(1);
        src_d      = up_q ? src_q - AW'(1) : src_q + AW'(1);
        if (src_q == end_q) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_d = ins_q ? S_WRV : S_RESP;
      end

      S_WRV: begin
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.element     = '0;
          out_d.entry_count = CountW'(count_q);
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_LIST: begin
        if (out_free) begin
          out_d.status      = ST_OK;
          out_d.element     = rd_data;
          out_d.entry_count = CountW'(count_q);
          out_d.last        = (ptr_q == cnt_m1);
          out_valid_d       = 1'b1;
          if (ptr_q == cnt_m1) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next entry while this one goes out
            rd_en   = 1'b1;
            rd_addr = ptr_q + AW'(1);
            ptr_d   = ptr_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // moved word lands in the cycle after its read; the new value goes in last
  always_comb begin
    wr_en   = pend_q || (state_q == S_WRV);
    wr_addr = pend_q ? pend_dst_q : idx_q;
    wr_data = pend_q ? rd_data : val_q;
  end

  ple_ram #(
    .Width (ValueW),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_dst_q <= pend_dst_d;
    src_q      <= src_d;
    end_q      <= end_d;
    up_q       <= up_d;
    ins_q      <= ins_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    status_q   <= status_d;
    ptr_q      <= ptr_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire ple_pkg::in_req_t  in_req_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire ple_pkg::out_rsp_t out_rsp_o
);

  import ple_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // only a listing result can be non-final, and it is always ok
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last |-> out_rsp_o.status == ST_OK)
    else $error("non-final result with error status");

  // a refused request carries no element
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.last &&
    out_rsp_o.element == '0)
    else $error("refused request with element or follow-on results");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
